// File: rtl/core/jos_pkg.sv
// ----------------------------------------------------------------------------
// jos_pkg
// Shared types and field widths for the jet odd-even sorter.
// ----------------------------------------------------------------------------
package jos_pkg;

   localparam int ENERGY_W = 18;
   localparam int SEED_W   = 16;
   localparam int ETA_W    = 2;
   localparam int PHI_W    = 5;
   localparam int REC_W    = ENERGY_W + SEED_W + ETA_W + PHI_W;
   localparam int TDATA_W  = ((REC_W + 7) / 8) * 8;

   typedef struct packed {
      logic [PHI_W-1:0]    phi;
      logic [ETA_W-1:0]    eta;
      logic [SEED_W-1:0]   seed;
      logic [ENERGY_W-1:0] energy;
   } jet_rec_type;

   // per-cell control for one cycle
   typedef struct packed {
      logic shift;   // take the right neighbor's record
      logic cmp_lo;  // lower cell of a compare pair
      logic cmp_hi;  // upper cell of a compare pair
   } cell_ctrl_type;

endpackage

// File: rtl/core/jos_cell.sv
// ----------------------------------------------------------------------------
// jos_cell
// One sorter cell: holds a jet record; shifts or compare-exchanges with a
// neighbor.
// ----------------------------------------------------------------------------
module jos_cell (
   input  logic                   clock,
   input  jos_pkg::cell_ctrl_type ctrl,
   input  jos_pkg::jet_rec_type   left_rec,
   input  jos_pkg::jet_rec_type   right_rec,
   output jos_pkg::jet_rec_type   rec
);
   import jos_pkg::*;

   jet_rec_type rec_ff;
   jet_rec_type rec_in;

   always_comb begin
      rec_in = rec_ff;
      priority if (ctrl.shift) begin
         rec_in = right_rec;
      end else if (ctrl.cmp_lo) begin
         // larger energy moves to the lower index; ties stay put
         if (right_rec.energy > rec_ff.energy) rec_in = right_rec;
      end else if (ctrl.cmp_hi) begin
         if (rec_ff.energy > left_rec.energy) rec_in = left_rec;
      end else begin
         rec_in = rec_ff;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

   assign rec = rec_ff;

endmodule

// File: rtl/core/jet_odd_even_sorter_core.sv
// ----------------------------------------------------------------------------
// jet_odd_even_sorter_core
// Collects a set of jet records and emits them sorted by descending energy.
// ----------------------------------------------------------------------------
// Usage:
//   req_* : one jet record per request. NUM_ENTRIES requests form a set,
//           sector 0 first, then sector 1. req_tready is high only while
//           the set is loading.
//   rsp_* : after a full set, the top NUM_OUT (at most NUM_ENTRIES) records
//           in descending energy; equal energies keep arrival order.
//           rsp_tlast marks the final record of the set.
// Per set: the requests are loaded, then the sort runs one odd-even
//   transposition stage per cycle across the cell row, then one record is
//   emitted per cycle when the receiver is ready.
// Stall: while rsp_tready is low the head record is held and the row does
//   not shift; no new request is taken until the set has drained.
// Reset: returns to loading with an empty set. Cell contents are not reset;
//   every cell is overwritten before it is read.
// ----------------------------------------------------------------------------
module jet_odd_even_sorter_core #(
   parameter int NUM_ENTRIES = 10,
   parameter int NUM_OUT     = 9
) (
   input  logic                         clock,
   input  logic                         reset,
   // req_tdata: energy[17:0], seed_energy[33:18], eta[35:34], phi[40:36]
   input  logic [jos_pkg::TDATA_W-1:0]  req_tdata,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // rsp_tdata: energy[17:0], seed_energy[33:18], eta[35:34], phi[40:36]
   output logic [jos_pkg::TDATA_W-1:0]  rsp_tdata,
   output logic                         rsp_tlast,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready
);
   import jos_pkg::*;

   localparam int N_EMIT = (NUM_OUT < NUM_ENTRIES) ? NUM_OUT : NUM_ENTRIES;
   localparam int CNT_W  = $clog2(NUM_ENTRIES + 1);

   typedef enum logic [2:0] {
      ST_LOAD = 3'b001,
      ST_SORT = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;   // load, stage or emit count by state

   logic        req_fire;
   logic        rsp_fire;
   logic        cnt_done;
   jet_rec_type req_rec;

   jet_rec_type   cell_rec [NUM_ENTRIES];
   cell_ctrl_type cell_ctrl [NUM_ENTRIES];

   assign req_tready = (state_ff == ST_LOAD);
   assign rsp_tvalid = (state_ff == ST_EMIT);
   assign req_fire   = req_tvalid & req_tready;
   assign rsp_fire   = rsp_tvalid & rsp_tready;

   // unpack request, lowest field first
   assign req_rec.energy = req_tdata[ENERGY_W-1:0];
   assign req_rec.seed   = req_tdata[ENERGY_W +: SEED_W];
   assign req_rec.eta    = req_tdata[ENERGY_W + SEED_W +: ETA_W];
   assign req_rec.phi    = req_tdata[ENERGY_W + SEED_W + ETA_W +: PHI_W];

   // head of the row drives the response
   assign rsp_tdata = TDATA_W'({cell_rec[0].phi, cell_rec[0].eta,
                                cell_rec[0].seed, cell_rec[0].energy});

   always_comb begin
      unique case (state_ff)
         ST_LOAD: cnt_done = (cnt_ff == CNT_W'(NUM_ENTRIES - 1));
         ST_SORT: cnt_done = (cnt_ff == CNT_W'(NUM_ENTRIES - 1));
         ST_EMIT: cnt_done = (cnt_ff == CNT_W'(N_EMIT - 1));
         default: cnt_done = 1'b0;
      endcase
   end

   assign rsp_tlast = cnt_done;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               cnt_in = cnt_done ? '0 : cnt_ff + 1'b1;
               if (cnt_done) state_in = ST_SORT;
            end
         end
         ST_SORT: begin
            cnt_in = cnt_done ? '0 : cnt_ff + 1'b1;
            if (cnt_done) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_fire) begin
               cnt_in = cnt_done ? '0 : cnt_ff + 1'b1;
               if (cnt_done) state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
            cnt_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // cell row: loads shift in at the top end, emits shift out at cell 0,
   // sort stages pair cells by the parity of the stage count
   genvar gi;
   generate
      for (gi = 0; gi < NUM_ENTRIES; gi++) begin : g_cell
         localparam logic PAR = 1'(gi % 2);
         jet_rec_type left_rec;
         jet_rec_type right_rec;

         if (gi == 0) begin : g_left_end
            assign left_rec = '0;
         end else begin : g_left
            assign left_rec = cell_rec[gi-1];
         end

         if (gi == NUM_ENTRIES - 1) begin : g_right_end
            assign right_rec = req_rec;
         end else begin : g_right
            assign right_rec = cell_rec[gi+1];
         end

         assign cell_ctrl[gi].shift  = req_fire | rsp_fire;
         assign cell_ctrl[gi].cmp_lo = (state_ff == ST_SORT) &&
                                       (gi + 1 < NUM_ENTRIES) &&
                                       (cnt_ff[0] == PAR);
         assign cell_ctrl[gi].cmp_hi = (state_ff == ST_SORT) && (gi >= 1) &&
                                       (cnt_ff[0] != PAR);

         jos_cell u_cell (
            .clock     (clock),
            .ctrl      (cell_ctrl[gi]),
            .left_rec  (left_rec),
            .right_rec (right_rec),
            .rec       (cell_rec[gi])
         );
      end
   endgenerate

endmodule
